@@ rtl/lse_pkg.sv @@
package lse_pkg;

   localparam int SPECIES_COUNT = 32;
   localparam int SP_AW         = $clog2(SPECIES_COUNT);
   localparam int SP_W          = 5;
   localparam int DIAM_W        = 16;
   localparam int XB_W          = 16;
   localparam int EFF_W         = 17;
   localparam int LOG_FRAC      = 24;
   localparam int LOG_W         = 4 + LOG_FRAC;
   localparam int Q_W           = 27;
   localparam int N_W           = 6;
   localparam int N_LIMIT       = 40;
   localparam int TAYLOR_TERMS  = 16;
   localparam int SUM_W         = 35;

   localparam logic [31:0]      LN2_Q32 = 32'hB172_17F8;
   localparam logic [EFF_W-1:0] EFF_ONE = 17'd65536;

   localparam logic MODE_EVAL = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_X0_ZERO = 2'd1,
      ST_XB_ZERO = 2'd2
   } status_type;

   typedef struct packed {
      logic       valid;
      status_type status;
   } ctl_type;

   typedef struct packed {
      logic [DIAM_W-1:0] x0;
      logic [XB_W-1:0]   xb;
      logic [DIAM_W-1:0] mind;
   } entry_type;

endpackage

@@ rtl/lse_coef_mem.sv @@
module lse_coef_mem import lse_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [SP_AW-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [SP_AW-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem_ff [SPECIES_COUNT];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lse_log2.sv @@
module lse_log2 import lse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  ctl_type           ctl_in,
   input  logic [DIAM_W-1:0] a_in,
   input  logic [DIAM_W-1:0] b_in,
   input  logic [XB_W-1:0]   xbm_in,
   input  logic              kill_in,
   output ctl_type           ctl_out,
   output logic [LOG_W-1:0]  la_out,
   output logic [LOG_W-1:0]  lb_out,
   output logic [XB_W-1:0]   xbm_out,
   output logic              kill_out
);

   function automatic logic [3:0] msb_index(logic [DIAM_W-1:0] v);
      logic [3:0] p;
      p = 4'd0;
      for (int i = 1; i < DIAM_W; i++) begin
         if (v[i]) begin
            p = 4'(i);
         end
      end
      return p;
   endfunction

   logic [30:0]         m_ff    [0:LOG_FRAC][0:1];
   logic [LOG_FRAC-1:0] frac_ff [0:LOG_FRAC][0:1];
   logic [3:0]          p_ff    [0:LOG_FRAC][0:1];
   ctl_type             ctl_ff  [0:LOG_FRAC];
   logic [XB_W-1:0]     xbm_ff  [0:LOG_FRAC];
   logic                kill_ff [0:LOG_FRAC];

   logic [DIAM_W-1:0] v_in [0:1];
   logic [3:0]        p_in [0:1];
   logic [30:0]       m_in [0:1];

   always_comb begin
      v_in[0] = a_in;
      v_in[1] = b_in;
      for (int l = 0; l < 2; l++) begin
         p_in[l] = msb_index(v_in[l]);
         m_in[l] = 31'({31'b0, v_in[l]} << (5'd30 - {1'b0, p_in[l]}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            m_ff[0][l]    <= m_in[l];
            p_ff[0][l]    <= p_in[l];
            frac_ff[0][l] <= '0;
         end
         xbm_ff[0]  <= xbm_in;
         kill_ff[0] <= kill_in;
      end
   end

   for (genvar s = 1; s <= LOG_FRAC; s++) begin : g_sq
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [61:0] sq;
         logic [31:0] mm;

         always_comb begin
            sq = m_ff[s-1][l] * m_ff[s-1][l];
            mm = sq[61:30];
         end

         always_ff @(posedge clock) begin
            if (en) begin
               m_ff[s][l]    <= mm[31] ? mm[31:1] : mm[30:0];
               frac_ff[s][l] <= {frac_ff[s-1][l][LOG_FRAC-2:0], mm[31]};
               p_ff[s][l]    <= p_ff[s-1][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (en) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            xbm_ff[s]  <= xbm_ff[s-1];
            kill_ff[s] <= kill_ff[s-1];
         end
      end
   end

   assign ctl_out  = ctl_ff[LOG_FRAC];
   assign la_out   = {p_ff[LOG_FRAC][0], frac_ff[LOG_FRAC][0]};
   assign lb_out   = {p_ff[LOG_FRAC][1], frac_ff[LOG_FRAC][1]};
   assign xbm_out  = xbm_ff[LOG_FRAC];
   assign kill_out = kill_ff[LOG_FRAC];

endmodule

@@ rtl/lse_div.sv @@
module lse_div import lse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  ctl_type          ctl_in,
   input  logic [LOG_W-1:0] lnm_in,
   input  logic [XB_W-1:0]  xbm_in,
   input  logic             kill_in,
   output ctl_type          ctl_out,
   output logic [Q_W-1:0]   q_out,
   output logic             kill_out
);

   ctl_type         ctl_ff  [0:Q_W];
   logic            kill_ff [0:Q_W];
   logic [XB_W:0]   rem_ff  [0:Q_W];
   logic [Q_W-1:0]  low_ff  [0:Q_W];
   logic [Q_W-1:0]  q_ff    [0:Q_W];
   logic [XB_W-1:0] xbm_ff  [0:Q_W];

   logic ovf_in;

   assign ovf_in = {3'b0, lnm_in} >= {xbm_in, 15'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kill_ff[0] <= kill_in | ovf_in;
         rem_ff[0]  <= (XB_W+1)'(lnm_in >> 15);
         low_ff[0]  <= {lnm_in[14:0], 12'b0};
         q_ff[0]    <= '0;
         xbm_ff[0]  <= xbm_in;
      end
   end

   for (genvar s = 1; s <= Q_W; s++) begin : g_bit
      logic [XB_W+1:0] rr;
      logic            ge;

      always_comb begin
         rr = {rem_ff[s-1], low_ff[s-1][Q_W-1]};
         ge = rr >= {2'b0, xbm_ff[s-1]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (en) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= (XB_W+1)'(ge ? rr - {2'b0, xbm_ff[s-1]} : rr);
            low_ff[s]  <= {low_ff[s-1][Q_W-2:0], 1'b0};
            q_ff[s]    <= {q_ff[s-1][Q_W-2:0], ge};
            xbm_ff[s]  <= xbm_ff[s-1];
            kill_ff[s] <= kill_ff[s-1];
         end
      end
   end

   assign ctl_out  = ctl_ff[Q_W];
   assign q_out    = q_ff[Q_W];
   assign kill_out = kill_ff[Q_W];

endmodule

@@ rtl/lse_exp.sv @@
module lse_exp import lse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  ctl_type          ctl_in,
   input  logic [Q_W-1:0]   q_in,
   input  logic             kill_in,
   output ctl_type          ctl_out,
   output logic [EFF_W-1:0] eff_out
);

   typedef struct packed {
      logic                    kill;
      logic [N_W-1:0]          n;
      logic [31:0]             r;
      logic signed [SUM_W-1:0] sum;
   } base_type;

   // square, then n = floor(X / ln2) one bit a stage
   logic [53:0]    sq;
   ctl_type        nr_ctl_ff  [0:N_W];
   logic           nr_kill_ff [0:N_W];
   logic [36:0]    nr_rem_ff  [0:N_W];
   logic [N_W-1:0] nr_n_ff    [0:N_W];

   assign sq = q_in * q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         nr_ctl_ff[0] <= '0;
      end else if (en) begin
         nr_ctl_ff[0] <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nr_kill_ff[0] <= kill_in;
         nr_rem_ff[0]  <= {sq[53:25], 8'b0};
         nr_n_ff[0]    <= '0;
      end
   end

   for (genvar t = 1; t <= N_W; t++) begin : g_n
      localparam logic [37:0] THR = {6'b0, LN2_Q32} << (N_W - t);
      logic ge;

      assign ge = {1'b0, nr_rem_ff[t-1]} >= THR;

      always_ff @(posedge clock) begin
         if (reset) begin
            nr_ctl_ff[t] <= '0;
         end else if (en) begin
            nr_ctl_ff[t] <= nr_ctl_ff[t-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nr_rem_ff[t]  <= ge ? 37'({1'b0, nr_rem_ff[t-1]} - THR) : nr_rem_ff[t-1];
            nr_n_ff[t]    <= {nr_n_ff[t-1][N_W-2:0], ge};
            nr_kill_ff[t] <= nr_kill_ff[t-1];
         end
      end
   end

   // Taylor series of exp(-r), three stages per term
   base_type    first_base;
   logic [31:0] first_r;

   always_comb begin
      first_r         = nr_rem_ff[N_W][31:0];
      first_base.kill = nr_kill_ff[N_W] | (32'(nr_n_ff[N_W]) >= N_LIMIT);
      first_base.n    = nr_n_ff[N_W];
      first_base.r    = first_r;
      first_base.sum  = $signed({3'b001, 32'b0}) - $signed({3'b000, first_r});
   end

   ctl_type     ta_ctl_ff  [2:TAYLOR_TERMS];
   ctl_type     tb_ctl_ff  [2:TAYLOR_TERMS];
   ctl_type     tc_ctl_ff  [2:TAYLOR_TERMS];
   base_type    ta_base_ff [2:TAYLOR_TERMS];
   base_type    tb_base_ff [2:TAYLOR_TERMS];
   base_type    tc_base_ff [2:TAYLOR_TERMS];
   logic [63:0] ta_prod_ff [2:TAYLOR_TERMS];
   logic [31:0] tb_a_ff    [2:TAYLOR_TERMS];
   logic [63:0] tb_mul_ff  [2:TAYLOR_TERMS];
   logic [31:0] tc_term_ff [2:TAYLOR_TERMS];

   for (genvar k = 2; k <= TAYLOR_TERMS; k++) begin : g_term
      localparam logic [31:0] KV    = 32'(k);
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / k);
      localparam bit          ODD   = (k % 2) == 1;

      ctl_type     src_ctl;
      base_type    src_base;
      logic [31:0] src_term;
      logic [31:0] qe;
      logic [31:0] rem;
      logic [31:0] t_in;
      base_type    base_in;

      if (k == 2) begin : g_first
         assign src_ctl  = nr_ctl_ff[N_W];
         assign src_base = first_base;
         assign src_term = first_r;
      end else begin : g_next
         assign src_ctl  = tc_ctl_ff[k-1];
         assign src_base = tc_base_ff[k-1];
         assign src_term = tc_term_ff[k-1];
      end

      always_comb begin
         qe      = tb_mul_ff[k][63:32];
         rem     = tb_a_ff[k] - 32'(qe * KV);
         t_in    = (rem >= KV) ? qe + 32'd1 : qe;
         base_in = tb_base_ff[k];
         if (ODD) begin
            base_in.sum = $signed(tb_base_ff[k].sum) - $signed({3'b000, t_in});
         end else begin
            base_in.sum = $signed(tb_base_ff[k].sum) + $signed({3'b000, t_in});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ta_ctl_ff[k] <= '0;
            tb_ctl_ff[k] <= '0;
            tc_ctl_ff[k] <= '0;
         end else if (en) begin
            ta_ctl_ff[k] <= src_ctl;
            tb_ctl_ff[k] <= ta_ctl_ff[k];
            tc_ctl_ff[k] <= tb_ctl_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ta_base_ff[k] <= src_base;
            ta_prod_ff[k] <= src_term * src_base.r;
            tb_base_ff[k] <= ta_base_ff[k];
            tb_a_ff[k]    <= ta_prod_ff[k][63:32];
            tb_mul_ff[k]  <= ta_prod_ff[k][63:32] * RECIP;
            tc_base_ff[k] <= base_in;
            tc_term_ff[k] <= t_in;
         end
      end
   end

   // round, scale by 2^-n, saturate
   base_type         last;
   logic [33:0]      pos_sum;
   logic [6:0]       sh;
   logic [55:0]      wide;
   logic [55:0]      res;
   logic [EFF_W-1:0] eff_in;
   ctl_type          ctl_ff;
   logic [EFF_W-1:0] eff_ff;

   always_comb begin
      last    = tc_base_ff[TAYLOR_TERMS];
      pos_sum = last.sum[SUM_W-1] ? 34'd0 : last.sum[33:0];
      sh      = 7'd15 + {1'b0, last.n};
      wide    = {22'b0, pos_sum} + (56'd1 << sh);
      res     = wide >> (sh + 7'd1);
      if (last.kill) begin
         eff_in = '0;
      end else if (res > {39'b0, EFF_ONE}) begin
         eff_in = EFF_ONE;
      end else begin
         eff_in = res[EFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= tc_ctl_ff[TAYLOR_TERMS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         eff_ff <= eff_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign eff_out = eff_ff;

endmodule

@@ rtl/lognormal_size_effect.sv @@
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | mode, species, diameter, mode_diameter,
//         |           |                     | log_spread, min_diameter
// rsp     | out       | rsp_valid/rsp_stall | size_effect, status
//
// One request per cycle while req_stall is low; each request passes through the 24
// squaring stages of the log unit, the 27 quotient stages of the divider and the
// 16-term series of the exponent unit.
// Reset clears only the pipeline valid and status bits; the coefficient table
// holds no defined value until a species is loaded.
// A stalled response is held in the output register and one more in a skid
// register; the request side stalls only while the skid register is full.
module lognormal_size_effect import lse_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_mode,
   input  logic [SP_W-1:0]         req_species,
   input  logic [DIAM_W-1:0]       req_diameter,
   input  logic [DIAM_W-1:0]       req_mode_diameter,
   input  logic signed [XB_W-1:0]  req_log_spread,
   input  logic [DIAM_W-1:0]       req_min_diameter,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [EFF_W-1:0]        rsp_size_effect,
   output logic [1:0]              rsp_status
);

   logic       en;
   logic       accept;
   logic       in_range;
   logic       wr_en;
   entry_type  wr_data;
   entry_type  rd_data;
   status_type status_in;

   logic             out_valid_ff;
   logic [EFF_W-1:0] out_eff_ff;
   status_type       out_status_ff;
   logic             skid_valid_ff;
   logic [EFF_W-1:0] skid_eff_ff;
   status_type       skid_status_ff;
   logic             out_free;
   logic             new_item;

   assign en       = !skid_valid_ff;
   assign accept   = req_valid && en;
   assign in_range = 32'(req_species) < SPECIES_COUNT;
   assign wr_en    = accept && (req_mode == MODE_LOAD) && (req_mode_diameter != '0)
                     && (req_log_spread != '0) && in_range;
   assign wr_data  = '{x0: req_mode_diameter, xb: XB_W'(req_log_spread),
                       mind: req_min_diameter};

   always_comb begin
      status_in = ST_OK;
      if (req_mode == MODE_LOAD) begin
         if (req_mode_diameter == '0) begin
            status_in = ST_X0_ZERO;
         end else if (req_log_spread == '0) begin
            status_in = ST_XB_ZERO;
         end
      end
   end

   lse_coef_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_species[SP_AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (en),
      .rd_addr (req_species[SP_AW-1:0]),
      .rd_data (rd_data)
   );

   // table read
   ctl_type           s1_ctl_ff;
   logic              s1_load_ff;
   logic              s1_range_ff;
   logic [DIAM_W-1:0] s1_diam_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (en) begin
         s1_ctl_ff <= '{valid: req_valid, status: status_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_load_ff  <= req_mode == MODE_LOAD;
         s1_range_ff <= in_range;
         s1_diam_ff  <= req_diameter;
      end
   end

   // clamp diameter, flag trivial cases
   logic [DIAM_W-1:0] d_in;
   logic              kill_in;
   logic [XB_W-1:0]   xbm_in;
   ctl_type           s2_ctl_ff;
   logic [DIAM_W-1:0] s2_d_ff;
   logic [DIAM_W-1:0] s2_x0_ff;
   logic [XB_W-1:0]   s2_xbm_ff;
   logic              s2_kill_ff;

   always_comb begin
      d_in    = (s1_diam_ff < rd_data.mind) ? rd_data.mind : s1_diam_ff;
      kill_in = s1_load_ff || !s1_range_ff || (d_in == '0) || (rd_data.x0 == '0)
                || (rd_data.xb == '0);
      xbm_in  = rd_data.xb[XB_W-1] ? XB_W'(-rd_data.xb) : rd_data.xb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (en) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_d_ff    <= d_in;
         s2_x0_ff   <= rd_data.x0;
         s2_xbm_ff  <= xbm_in;
         s2_kill_ff <= kill_in;
      end
   end

   ctl_type          lg_ctl;
   logic [LOG_W-1:0] lg_la;
   logic [LOG_W-1:0] lg_lb;
   logic [XB_W-1:0]  lg_xbm;
   logic             lg_kill;

   lse_log2 u_log2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (s2_ctl_ff),
      .a_in     (s2_d_ff),
      .b_in     (s2_x0_ff),
      .xbm_in   (s2_xbm_ff),
      .kill_in  (s2_kill_ff),
      .ctl_out  (lg_ctl),
      .la_out   (lg_la),
      .lb_out   (lg_lb),
      .xbm_out  (lg_xbm),
      .kill_out (lg_kill)
   );

   // |log2 d - log2 x0|, then scale by ln2
   ctl_type          s3_ctl_ff;
   logic [LOG_W-1:0] s3_l_ff;
   logic [XB_W-1:0]  s3_xbm_ff;
   logic             s3_kill_ff;
   logic [LOG_W-1:0] l_in;
   logic [63:0]      lnm_prod;
   logic [LOG_W-1:0] lnm_in;
   ctl_type          s4_ctl_ff;
   logic [LOG_W-1:0] s4_lnm_ff;
   logic [XB_W-1:0]  s4_xbm_ff;
   logic             s4_kill_ff;

   always_comb begin
      l_in     = (lg_la >= lg_lb) ? lg_la - lg_lb : lg_lb - lg_la;
      lnm_prod = s3_l_ff * LN2_Q32;
      lnm_in   = LOG_W'((lnm_prod + 64'h8000_0000) >> 32);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
      end else if (en) begin
         s3_ctl_ff <= lg_ctl;
         s4_ctl_ff <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_l_ff    <= l_in;
         s3_xbm_ff  <= lg_xbm;
         s3_kill_ff <= lg_kill;
         s4_lnm_ff  <= lnm_in;
         s4_xbm_ff  <= s3_xbm_ff;
         s4_kill_ff <= s3_kill_ff;
      end
   end

   ctl_type        dv_ctl;
   logic [Q_W-1:0] dv_q;
   logic           dv_kill;

   lse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (s4_ctl_ff),
      .lnm_in   (s4_lnm_ff),
      .xbm_in   (s4_xbm_ff),
      .kill_in  (s4_kill_ff),
      .ctl_out  (dv_ctl),
      .q_out    (dv_q),
      .kill_out (dv_kill)
   );

   ctl_type          ex_ctl;
   logic [EFF_W-1:0] ex_eff;

   lse_exp u_exp (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (dv_ctl),
      .q_in    (dv_q),
      .kill_in (dv_kill),
      .ctl_out (ex_ctl),
      .eff_out (ex_eff)
   );

   // output register and skid
   assign out_free = !out_valid_ff || !rsp_stall;
   assign new_item = en && ex_ctl.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || new_item;
         skid_valid_ff <= 1'b0;
      end else if (new_item) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_eff_ff    <= skid_eff_ff;
            out_status_ff <= skid_status_ff;
         end else begin
            out_eff_ff    <= ex_eff;
            out_status_ff <= ex_ctl.status;
         end
      end else if (new_item) begin
         skid_eff_ff    <= ex_eff;
         skid_status_ff <= ex_ctl.status;
      end
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_size_effect = out_eff_ff;
   assign rsp_status      = out_status_ff;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import lse_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD  = 400;

   typedef struct {
      logic [EFF_W-1:0] size_effect;
      status_type       status;
   } effect_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_mode;
   logic [SP_W-1:0]        req_species;
   logic [DIAM_W-1:0]      req_diameter;
   logic [DIAM_W-1:0]      req_mode_diameter;
   logic signed [XB_W-1:0] req_log_spread;
   logic [DIAM_W-1:0]      req_min_diameter;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [EFF_W-1:0]       rsp_size_effect;
   logic [1:0]             rsp_status;

   entry_type  species_table [SPECIES_COUNT];
   bit         species_loaded [SPECIES_COUNT];
   effect_type pending_effects [$];
   int         errors;
   int         idle_cycles;
   int         burst_left;
   bit         long_hold_go;
   int         hold_left;
   int         pattern_cycle;
   int         pattern_kind;

   lognormal_size_effect u_top (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint unsigned log2_q24(logic [15:0] v);
      int p;
      longint unsigned m;
      longint unsigned frac;
      p = 0;
      frac = 0;
      while (p < 15 && (v >> (p + 1)) != 0) p++;
      m = longint'(v) << (30 - p);
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac |= 64'd1 << i;
         end
      end
      return (longint'(p) << 24) | frac;
   endfunction

   function automatic logic [EFF_W-1:0] size_effect_of(logic [15:0] diam, entry_type e);
      longint unsigned la, lb, l, xbm, lnm, q, x, big_x, n, r, term, res;
      longint sum;
      logic [15:0] d;
      d = (diam < e.mind) ? e.mind : diam;
      if (d == 0 || e.x0 == 0 || e.xb == 0) return '0;
      la = log2_q24(d);
      lb = log2_q24(e.x0);
      l = (la >= lb) ? la - lb : lb - la;
      lnm = (l * 64'(LN2_Q32) + (64'd1 << 31)) >> 32;
      xbm = e.xb[15] ? (64'h10000 - e.xb) : e.xb;
      q = (lnm << 12) / xbm;
      if (q >= (64'd8 << 24)) return '0;
      x = (q * q) >> 25;
      big_x = x << 8;
      n = big_x / 64'(LN2_Q32);
      r = big_x - n * 64'(LN2_Q32);
      if (n >= N_LIMIT) return '0;
      sum = longint'(64'd1 << 32);
      term = 64'd1 << 32;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
         term = ((term * r) >> 32) / longint'(k);
         if (k % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      res = (longint'(sum) + (64'd1 << (15 + n))) >> (16 + n);
      if (res > 65536) res = 65536;
      return res[EFF_W-1:0];
   endfunction

   always @(posedge clock) begin
      effect_type e;
      if (!reset && req_valid && !req_stall) begin
         e.size_effect = '0;
         e.status = ST_OK;
         if (req_mode == MODE_LOAD) begin
            if (req_mode_diameter == 0) e.status = ST_X0_ZERO;
            else if (req_log_spread == 0) e.status = ST_XB_ZERO;
            else if (req_species < SPECIES_COUNT) begin
               species_table[req_species] = '{x0: req_mode_diameter,
                  xb: req_log_spread, mind: req_min_diameter};
            end
         end else if (req_species < SPECIES_COUNT) begin
            e.size_effect = size_effect_of(req_diameter, species_table[req_species]);
         end
         pending_effects.push_back(e);
      end
   end

   always @(posedge clock) begin
      effect_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_effects.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            e = pending_effects.pop_front();
            if (rsp_size_effect !== e.size_effect) begin
               $error("size_effect expected %0d actual %0d", e.size_effect,
                  rsp_size_effect);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   always @(negedge clock) begin
      if (long_hold_go) begin
         long_hold_go = 1'b0;
         hold_left = LONG_HOLD;
      end
      pattern_cycle++;
      if (pattern_cycle % 64 == 0) pattern_kind = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (pattern_kind)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= (pattern_cycle % 5 < 2);
         endcase
      end
   end

   task automatic send_request(logic mode, logic [SP_W-1:0] sp, logic [15:0] diam,
                               logic [15:0] x0, logic [15:0] xb, logic [15:0] mind);
      @(negedge clock);
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_species       <= sp;
      req_diameter      <= diam;
      req_mode_diameter <= x0;
      req_log_spread    <= xb;
      req_min_diameter  <= mind;
      if (mode == MODE_LOAD && x0 != 0 && xb != 0) species_loaded[sp] = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   task automatic pause_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic load_species(logic [SP_W-1:0] sp, logic [15:0] x0, logic [15:0] xb,
                               logic [15:0] mind);
      send_request(MODE_LOAD, sp, 16'($urandom), x0, xb, mind);
   endtask

   task automatic evaluate(logic [SP_W-1:0] sp, logic [15:0] diam);
      send_request(MODE_EVAL, sp, diam, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   function automatic logic [SP_W-1:0] pick_loaded();
      logic [SP_W-1:0] sp;
      do sp = SP_W'($urandom_range(0, SPECIES_COUNT - 1)); while (!species_loaded[sp]);
      return sp;
   endfunction

   task automatic random_item();
      logic [15:0] x0, xb;
      if (burst_left == 0) begin
         pause_sender($urandom_range(0, 6));
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      if ($urandom_range(0, 3) == 0) begin
         x0 = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
         xb = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
         load_species(SP_W'($urandom), x0, xb,
            ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255)));
      end else begin
         logic [SP_W-1:0] sp;
         sp = pick_loaded();
         case ($urandom_range(0, 2))
            0: evaluate(sp, 16'($urandom));
            1: evaluate(sp, species_table[sp].x0 + 16'($urandom_range(0, 255)) - 16'd128);
            default: evaluate(sp, species_table[sp].x0 ^ (16'd1 << $urandom_range(0, 15)));
         endcase
      end
   endtask

   task automatic test_load_and_reject();
      load_species(0, 16'd640, 16'h1000, 16'd0);
      load_species(31, 16'hFFFF, 16'h7FFF, 16'hFFFF);
      load_species(5, 16'd1, 16'sh8000, 16'd64);
      load_species(7, 16'd0, 16'h1000, 16'd10);
      load_species(7, 16'd0, 16'd0, 16'd10);
      load_species(7, 16'd320, 16'd0, 16'd10);
      load_species(9, 16'd320, 16'hF000, 16'd0);
      load_species(12, 16'd1000, 16'd1, 16'd0);
   endtask

   task automatic test_evaluate_extremes();
      evaluate(0, 16'd640);
      evaluate(0, 16'd0);
      evaluate(0, 16'hFFFF);
      evaluate(0, 16'd1);
      evaluate(31, 16'd0);
      evaluate(31, 16'hFFFF);
      evaluate(5, 16'd0);
      evaluate(5, 16'hFFFF);
      evaluate(9, 16'd400);
      evaluate(9, 16'd0);
      evaluate(12, 16'd1000);
      evaluate(12, 16'd1001);
      evaluate(0, 16'd900);
   endtask

   task automatic test_random_traffic();
      burst_left = 0;
      repeat (230) random_item();
   endtask

   task automatic test_backpressure();
      long_hold_go = 1'b1;
      repeat (150) begin
         send_request(MODE_EVAL, pick_loaded(), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      errors        = 0;
      long_hold_go  = 1'b0;
      hold_left     = 0;
      pattern_cycle = 0;
      pattern_kind  = 0;
      foreach (species_loaded[i]) species_loaded[i] = 1'b0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_mode          <= MODE_EVAL;
      req_species       <= '0;
      req_diameter      <= '0;
      req_mode_diameter <= '0;
      req_log_spread    <= '0;
      req_min_diameter  <= '0;
      rsp_stall         <= 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_load_and_reject();
      test_evaluate_extremes();
      test_random_traffic();
      test_backpressure();
      pause_sender(1);

      while (pending_effects.size() != 0) begin
         @(posedge clock);
      end
      repeat (150) @(posedge clock);
      if (errors == 0 && pending_effects.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/lse_pkg.sv
rtl/lse_coef_mem.sv
rtl/lse_log2.sv
rtl/lse_div.sv
rtl/lse_exp.sv
rtl/lognormal_size_effect.sv
verif/testbench.sv
